>>> sv/ctc_pkg.sv
`default_nettype none

package ctc_pkg;

  // Parameter defaults
  localparam int MAX_TOKENS_DEF     = 3;
  localparam int MAX_HEX_DIGITS_DEF = 5;

  localparam int VALUE_W      = 20;
  localparam int NUM_KEYWORDS = 3;

  // Byte codes
  localparam logic [7:0] CHAR_END     = 8'h00;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;

  // Keyword codes
  localparam logic [1:0] KW_LOAD  = 2'd0;
  localparam logic [1:0] KW_STORE = 2'd1;
  localparam logic [1:0] KW_RESET = 2'd2;

  typedef enum logic [1:0] {
    KIND_KEYWORD = 2'd0,
    KIND_NUMBER  = 2'd1,
    KIND_STRING  = 2'd2
  } ctc_kind_t;

  typedef struct packed {
    logic               token_valid;
    logic [1:0]         token_index;
    ctc_kind_t          token_kind;
    logic [1:0]         keyword_code;
    logic [VALUE_W-1:0] number_value;
    logic               message_done;
    logic [1:0]         token_count;
  } ctc_result_t;

  function automatic logic [2:0] kw_len(input logic [1:0] code);
    case (code)
      KW_LOAD:  kw_len = 3'd4;
      KW_STORE: kw_len = 3'd5;
      KW_RESET: kw_len = 3'd5;
      default:  kw_len = 3'd0;
    endcase
  endfunction

  // Byte at position pos of keyword code; only valid for pos < kw_len(code)
  function automatic logic [7:0] kw_char(input logic [1:0] code, input logic [2:0] pos);
    logic [39:0] txt;
    case (code)
      KW_LOAD:  txt = {"load", 8'h00};
      KW_STORE: txt = "store";
      KW_RESET: txt = "reset";
      default:  txt = '0;
    endcase
    case (pos)
      3'd0:    kw_char = txt[39:32];
      3'd1:    kw_char = txt[31:24];
      3'd2:    kw_char = txt[23:16];
      3'd3:    kw_char = txt[15:8];
      3'd4:    kw_char = txt[7:0];
      default: kw_char = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> sv/command_token_classifier_top.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall   | in_character
// out_    | output    | out_valid/out_stall | out_token_valid, out_token_index, out_token_kind,
//         |           |                     | out_keyword_code, out_number_value,
//         |           |                     | out_message_done, out_token_count
//
// One byte per cycle unless stalled; a byte's result appears on out_ in the next cycle.
// Throughput is set by the single result register: a byte is taken whenever that register
// is empty or being emptied in the same cycle.
// rst_n is synchronous, active low; it clears the token state and the result valid flag.
// in_stall rises only while a result is held and out_stall is high.
`default_nettype none

module command_token_classifier_top
  import ctc_pkg::*;
#(
  parameter int MAX_TOKENS     = MAX_TOKENS_DEF,
  parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_character,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_token_valid,
  output logic [1:0]              out_token_index,
  output logic [1:0]              out_token_kind,
  output logic [1:0]              out_keyword_code,
  output logic [VALUE_W-1:0]      out_number_value,
  output logic                    out_message_done,
  output logic [1:0]              out_token_count
);

  logic        in_take;
  ctc_result_t trk_res;
  logic        trk_res_valid;

  logic        out_valid_r, out_valid_nxt;
  ctc_result_t out_res_r;

  // The result register is free if empty or being drained this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  // Per-token classification state and result formation
  ctc_tracker #(
    .MAX_TOKENS     (MAX_TOKENS),
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .character (in_character),
    .res       (trk_res),
    .res_valid (trk_res_valid)
  );

  // Held while stalled; reloaded or emptied otherwise.
  assign out_valid_nxt = in_stall ? 1'b1 : (in_take & trk_res_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset, loaded only when a new result is taken
  always_ff @(posedge clk) begin
    if (in_take && trk_res_valid) begin
      out_res_r <= trk_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_valid  = out_res_r.token_valid;
  assign out_token_index  = out_res_r.token_index;
  assign out_token_kind   = out_res_r.token_kind;
  assign out_keyword_code = out_res_r.keyword_code;
  assign out_number_value = out_res_r.number_value;
  assign out_message_done = out_res_r.message_done;
  assign out_token_count  = out_res_r.token_count;

endmodule

`default_nettype wire

>>> sv/ctc_tracker.sv
`default_nettype none

module ctc_tracker
  import ctc_pkg::*;
#(
  parameter int MAX_TOKENS     = MAX_TOKENS_DEF,
  parameter int MAX_HEX_DIGITS = MAX_HEX_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  character,
  output ctc_result_t      res,
  output logic             res_valid
);

  localparam int POS_LIMIT = ((MAX_HEX_DIGITS + 3) > 7) ? (MAX_HEX_DIGITS + 3) : 7;
  localparam int POS_W     = $clog2(POS_LIMIT + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_LIMIT);
  localparam logic [POS_W-1:0] HEX_END = POS_W'(MAX_HEX_DIGITS + 2);
  localparam logic [1:0]       TOK_MAX = 2'(MAX_TOKENS);

  logic                    inside_r, inside_nxt;
  logic [1:0]              seen_r, seen_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [NUM_KEYWORDS-1:0] alive_r, alive_nxt;
  logic                    hex_ok_r, hex_ok_nxt;
  logic [VALUE_W-1:0]      acc_r, acc_nxt;

  // token state as seen by the incoming byte (cleared when a token opens)
  logic [POS_W-1:0]        b_pos;
  logic [NUM_KEYWORDS-1:0] b_alive;
  logic                    b_ok;
  logic [VALUE_W-1:0]      b_acc;

  // token state after the byte
  logic [POS_W-1:0]        t_pos;
  logic [NUM_KEYWORDS-1:0] t_alive;
  logic                    t_ok;
  logic [VALUE_W-1:0]      t_acc;

  logic        is_digit, is_upper_hex;
  logic [3:0]  digit;
  ctc_result_t emit_res;
  logic        kw_found;
  logic [1:0]  kw_code;

  always_comb begin
    b_pos   = inside_r ? pos_r   : '0;
    b_alive = inside_r ? alive_r : '1;
    b_ok    = inside_r ? hex_ok_r : 1'b1;
    b_acc   = inside_r ? acc_r   : '0;

    is_digit     = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    is_upper_hex = (character >= CHAR_UPPER_A) && (character <= CHAR_UPPER_F);
    digit        = is_digit ? character[3:0] : 4'(character - CHAR_UPPER_A + 8'd10);

    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      t_alive[k] = b_alive[k] && (b_pos < POS_W'(kw_len(2'(k)))) &&
                   (character == kw_char(2'(k), b_pos[2:0]));
    end

    t_ok  = b_ok;
    t_acc = b_acc;
    if (b_pos == POS_W'(0)) begin
      if (character != CHAR_ZERO) t_ok = 1'b0;
    end else if (b_pos == POS_W'(1)) begin
      if (character != CHAR_LOWER_X) t_ok = 1'b0;
    end else if (!(is_digit || is_upper_hex) || (b_pos >= HEX_END)) begin
      t_ok = 1'b0;
    end else begin
      t_acc = {b_acc[VALUE_W-5:0], digit};
    end

    t_pos = (b_pos < POS_MAX) ? b_pos + POS_W'(1) : b_pos;
  end

  // classification of the token held in the state registers
  always_comb begin
    kw_found = 1'b0;
    kw_code  = KW_LOAD;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (!kw_found && alive_r[k] && (pos_r == POS_W'(kw_len(2'(k))))) begin
        kw_found = 1'b1;
        kw_code  = 2'(k);
      end
    end

    emit_res.token_valid  = 1'b1;
    emit_res.token_index  = seen_r;
    emit_res.message_done = 1'b0;
    emit_res.token_count  = seen_r + 2'd1;
    emit_res.keyword_code = KW_LOAD;
    emit_res.number_value = '0;
    if (kw_found) begin
      emit_res.token_kind   = KIND_KEYWORD;
      emit_res.keyword_code = kw_code;
    end else if (hex_ok_r && (pos_r >= POS_W'(3))) begin
      emit_res.token_kind   = KIND_NUMBER;
      emit_res.number_value = acc_r;
    end else begin
      emit_res.token_kind   = KIND_STRING;
    end
  end

  always_comb begin
    inside_nxt = inside_r;
    seen_nxt   = seen_r;
    pos_nxt    = pos_r;
    alive_nxt  = alive_r;
    hex_ok_nxt = hex_ok_r;
    acc_nxt    = acc_r;

    res_valid        = 1'b0;
    res.token_valid  = 1'b0;
    res.token_index  = 2'd0;
    res.token_kind   = KIND_KEYWORD;
    res.keyword_code = KW_LOAD;
    res.number_value = '0;
    res.message_done = 1'b0;
    res.token_count  = seen_r;

    if (take) begin
      if (character == CHAR_END) begin
        res_valid = 1'b1;
        if (inside_r) res = emit_res;
        res.message_done = 1'b1;
        inside_nxt = 1'b0;
        seen_nxt   = 2'd0;
        pos_nxt    = '0;
        alive_nxt  = '1;
        hex_ok_nxt = 1'b1;
        acc_nxt    = '0;
      end else if (character == CHAR_SPACE) begin
        if (inside_r) begin
          res_valid  = 1'b1;
          res        = emit_res;
          seen_nxt   = seen_r + 2'd1;
          inside_nxt = 1'b0;
          pos_nxt    = '0;
          alive_nxt  = '1;
          hex_ok_nxt = 1'b1;
          acc_nxt    = '0;
        end
      end else if (inside_r || (seen_r < TOK_MAX)) begin
        inside_nxt = 1'b1;
        pos_nxt    = t_pos;
        alive_nxt  = t_alive;
        hex_ok_nxt = t_ok;
        acc_nxt    = t_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      seen_r   <= 2'd0;
      pos_r    <= '0;
      alive_r  <= '1;
      hex_ok_r <= 1'b1;
      acc_r    <= '0;
    end else begin
      inside_r <= inside_nxt;
      seen_r   <= seen_nxt;
      pos_r    <= pos_nxt;
      alive_r  <= alive_nxt;
      hex_ok_r <= hex_ok_nxt;
      acc_r    <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/ctc_checker.sv
`default_nettype none

module ctc_checker
  import ctc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [7:0]         in_character,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               out_token_valid,
  input wire logic [1:0]         out_token_index,
  input wire logic [1:0]         out_token_kind,
  input wire logic [1:0]         out_keyword_code,
  input wire logic [VALUE_W-1:0] out_number_value,
  input wire logic               out_message_done,
  input wire logic [1:0]         out_token_count
);

  // stalled byte beat stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_character))
    else $error("byte beat changed while stalled");

  // stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_number_value) &&
      $stable(out_token_count) && $stable(out_message_done))
    else $error("result beat changed while stalled");

  // a beat without a token only closes a message
  a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_token_valid |->
      out_message_done && (out_token_count <= 2'(MAX_TOKENS_DEF)))
    else $error("tokenless result not closing message");

  // count runs one ahead of index for a reported token
  a_count_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_valid |-> out_token_count == 2'(out_token_index + 2'd1))
    else $error("token count and index disagree");

  // value only carried by numbers
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind != KIND_NUMBER) |-> out_number_value == '0)
    else $error("value on non-number result");

endmodule

bind command_token_classifier_top ctc_checker u_ctc_checker (.*);

`default_nettype wire

>>> tb/command_token_classifier_top_tb.sv
module command_token_classifier_top_tb;
  import ctc_pkg::*;

  // Codes that the package leaves out
  localparam logic [1:0] NO_KEYWORD   = 2'd0;
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  // Token length is capped as in the block: hex digits plus "0x" plus one, at least 7
  localparam int LEN_CAP = (MAX_HEX_DIGITS_DEF + 3 > 7) ? MAX_HEX_DIGITS_DEF + 3 : 7;

  localparam int RANDOM_BYTES = 470;
  localparam int QUIET_LIMIT  = 1000;

  localparam ctc_result_t NO_CLAIM = '0;

  // One line of the opening script: a byte and, where it is plain to see, the result it gives
  typedef struct packed {
    logic [7:0]  ch;
    logic        typed;
    ctc_result_t want;
  } script_row_t;

  typedef struct packed {
    logic        typed;
    ctc_result_t want;
  } claim_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_character;
  logic               out_valid;
  logic               out_stall;
  logic               out_token_valid;
  logic [1:0]         out_token_index;
  logic [1:0]         out_token_kind;
  logic [1:0]         out_keyword_code;
  logic [VALUE_W-1:0] out_number_value;
  logic               out_message_done;
  logic [1:0]         out_token_count;

  command_token_classifier_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_character     (in_character),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_valid  (out_token_valid),
    .out_token_index  (out_token_index),
    .out_token_kind   (out_token_kind),
    .out_keyword_code (out_keyword_code),
    .out_number_value (out_number_value),
    .out_message_done (out_message_done),
    .out_token_count  (out_token_count)
  );

  // Opening script, three messages:
  //   an empty message with leading and repeated spaces;
  //   all three keywords, then a 0xFF byte past the token limit, which must be dropped;
  //   the largest five-digit number, closed by the end byte while still inside the token.
  script_row_t opening_script [30] = '{
    '{" ", 1'b0, NO_CLAIM},
    '{" ", 1'b0, NO_CLAIM},
    '{CHAR_END, 1'b1, '{1'b0, 2'd0, KIND_KEYWORD, NO_KEYWORD, 20'd0, 1'b1, 2'd0}},
    '{"l", 1'b0, NO_CLAIM},
    '{"o", 1'b0, NO_CLAIM},
    '{"a", 1'b0, NO_CLAIM},
    '{"d", 1'b0, NO_CLAIM},
    '{CHAR_SPACE, 1'b1, '{1'b1, 2'd0, KIND_KEYWORD, KW_LOAD, 20'd0, 1'b0, 2'd1}},
    '{"s", 1'b0, NO_CLAIM},
    '{"t", 1'b0, NO_CLAIM},
    '{"o", 1'b0, NO_CLAIM},
    '{"r", 1'b0, NO_CLAIM},
    '{"e", 1'b0, NO_CLAIM},
    '{CHAR_SPACE, 1'b1, '{1'b1, 2'd1, KIND_KEYWORD, KW_STORE, 20'd0, 1'b0, 2'd2}},
    '{"r", 1'b0, NO_CLAIM},
    '{"e", 1'b0, NO_CLAIM},
    '{"s", 1'b0, NO_CLAIM},
    '{"e", 1'b0, NO_CLAIM},
    '{"t", 1'b0, NO_CLAIM},
    '{CHAR_SPACE, 1'b1, '{1'b1, 2'd2, KIND_KEYWORD, KW_RESET, 20'd0, 1'b0, 2'd3}},
    '{8'hFF, 1'b0, NO_CLAIM},
    '{CHAR_END, 1'b1, '{1'b0, 2'd0, KIND_KEYWORD, NO_KEYWORD, 20'd0, 1'b1, 2'd3}},
    '{CHAR_ZERO, 1'b0, NO_CLAIM},
    '{CHAR_LOWER_X, 1'b0, NO_CLAIM},
    '{CHAR_UPPER_F, 1'b0, NO_CLAIM},
    '{CHAR_UPPER_F, 1'b0, NO_CLAIM},
    '{CHAR_UPPER_F, 1'b0, NO_CLAIM},
    '{CHAR_UPPER_F, 1'b0, NO_CLAIM},
    '{CHAR_UPPER_F, 1'b0, NO_CLAIM},
    '{CHAR_END, 1'b1, '{1'b1, 2'd0, KIND_NUMBER, NO_KEYWORD, 20'hFFFFF, 1'b1, 2'd1}}
  };

  // Keyword spellings, indexed by keyword code (filled at time zero)
  string kw_word [3];

  // Classifier state, kept alongside the block
  logic               tok_open;
  logic [1:0]         tok_done;
  int                 tok_len;
  logic [2:0]         kw_live;
  logic               hex_ok;
  logic [VALUE_W-1:0] hex_val;

  ctc_result_t pending_verdicts [$];
  claim_t      typed_claims [$];
  logic [7:0]  msg_q [$];

  int  errors;
  int  stall_left;
  bit  calm;
  int  quiet_cycles;
  int  bytes_taken;
  int  msgs_done;
  int  kind_tally [3];
  int  bare_ends;

  function automatic void clear_message();
    tok_open = 1'b0;
    tok_done = 2'd0;
    tok_len  = 0;
    kw_live  = 3'b111;
    hex_ok   = 1'b1;
    hex_val  = '0;
  endfunction

  // Verdict on the token now open: keyword beats number beats string
  function automatic ctc_result_t token_verdict();
    ctc_result_t v;
    bit          found;
    v = '0;
    v.token_valid  = 1'b1;
    v.token_index  = tok_done;
    v.token_kind   = KIND_STRING;
    v.keyword_code = NO_KEYWORD;
    v.token_count  = tok_done + 2'd1;
    found = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (!found && kw_live[k] && tok_len == kw_word[k].len()) begin
        found = 1'b1;
        v.keyword_code = 2'(k);
      end
    end
    if (found) begin
      v.token_kind = KIND_KEYWORD;
    end else if (hex_ok && tok_len >= 3) begin
      v.token_kind   = KIND_NUMBER;
      v.number_value = hex_val;
    end
    return v;
  endfunction

  // Advances the classifier by one byte; returns 1 when the byte yields a result
  function automatic bit classify_byte(input logic [7:0] c, output ctc_result_t res);
    bit         made;
    bit         digit_ok;
    logic [7:0] digit;
    made  = 1'b0;
    res   = '0;
    digit = '0;
    if (c == CHAR_END) begin
      if (tok_open) res = token_verdict();
      else res.token_count = tok_done;
      res.message_done = 1'b1;
      clear_message();
      made = 1'b1;
    end else if (c == CHAR_SPACE) begin
      if (tok_open) begin
        res      = token_verdict();
        tok_done = tok_done + 2'd1;
        tok_open = 1'b0;
        made     = 1'b1;
      end
    end else if (tok_open || tok_done < MAX_TOKENS_DEF) begin
      if (!tok_open) begin
        tok_open = 1'b1;
        tok_len  = 0;
        kw_live  = 3'b111;
        hex_ok   = 1'b1;
        hex_val  = '0;
      end
      for (int k = 0; k < 3; k++) begin
        if (!(tok_len < kw_word[k].len() && c == kw_word[k][tok_len])) kw_live[k] = 1'b0;
      end
      if (tok_len == 0) begin
        if (c != CHAR_ZERO) hex_ok = 1'b0;
      end else if (tok_len == 1) begin
        if (c != CHAR_LOWER_X) hex_ok = 1'b0;
      end else begin
        digit_ok = 1'b1;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) digit = c - CHAR_ZERO;
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) digit = c - CHAR_UPPER_A + 8'd10;
        else digit_ok = 1'b0;
        if (!digit_ok || tok_len - 2 >= MAX_HEX_DIGITS_DEF) hex_ok = 1'b0;
        else hex_val = {hex_val[VALUE_W-5:0], digit[3:0]};
      end
      if (tok_len < LEN_CAP) tok_len++;
    end
    return made;
  endfunction

  // Offers one byte after a drawn idle gap and holds it until the block takes it.
  // The claim rides along so the scoreboard can use a typed-in result instead.
  task automatic send_byte(input logic [7:0] c, input logic typed, input ctc_result_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    typed_claims.push_back('{typed, want});
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result-side backpressure: the drawn stall count only runs down while a result is held,
  // so every stall lands on a real beat. Between results the stall level is left as it is.
  always @(negedge clk) begin
    out_stall <= (stall_left > 0);
    if (out_valid && stall_left > 0) stall_left--;
  end

  // Scoreboard. Outputs are sampled at the rising edge, before the block's own updates land.
  // The result side is handled first so a beat leaving and a byte arriving on the same edge
  // pop and push the queue in the right order.
  always @(posedge clk) begin : scoreboard
    ctc_result_t want;
    ctc_result_t calc;
    claim_t      claim;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          $error("result beat arrived with nothing expected");
          errors++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_token_valid !== want.token_valid) begin
            $error("token_valid: expected %0d, got %0d", want.token_valid, out_token_valid);
            errors++;
          end
          if (out_token_index !== want.token_index) begin
            $error("token_index: expected %0d, got %0d", want.token_index, out_token_index);
            errors++;
          end
          if (out_token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d", want.token_kind, out_token_kind);
            errors++;
          end
          if (out_keyword_code !== want.keyword_code) begin
            $error("keyword_code: expected %0d, got %0d", want.keyword_code, out_keyword_code);
            errors++;
          end
          if (out_number_value !== want.number_value) begin
            $error("number_value: expected %0h, got %0h", want.number_value, out_number_value);
            errors++;
          end
          if (out_message_done !== want.message_done) begin
            $error("message_done: expected %0d, got %0d", want.message_done, out_message_done);
            errors++;
          end
          if (out_token_count !== want.token_count) begin
            $error("token_count: expected %0d, got %0d", want.token_count, out_token_count);
            errors++;
          end
          if (want.token_valid) kind_tally[want.token_kind]++;
          else bare_ends++;
        end
        stall_left = calm ? 0 : $urandom_range(0, 11);
      end
      if (in_valid && !in_stall) begin
        claim = typed_claims.pop_front();
        // The classifier always advances; a typed-in result, where given, replaces its verdict
        if (classify_byte(in_character, calc) || claim.typed)
          pending_verdicts.push_back(claim.typed ? claim.want : calc);
        bytes_taken++;
        if (in_character == CHAR_END) msgs_done++;
      end
    end
  end

  // Watchdog: any stretch with no beat on either side longer than the worst gap plus the
  // worst stall many times over means the block has hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no beat on either side for %0d cycles, %0d results outstanding",
             quiet_cycles, pending_verdicts.size());
      $display("command_token_classifier_top verification failed");
      $finish;
    end
  end

  initial begin
    script_row_t row;
    int          random_bytes;
    int          n_tok;
    int          n;
    int          d;
    logic [7:0]  b;
    string       word;

    kw_word[KW_LOAD]  = "load";
    kw_word[KW_STORE] = "store";
    kw_word[KW_RESET] = "reset";
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_character = CHAR_END;
    out_stall    = 1'b0;
    stall_left   = 0;
    calm         = 1'b0;
    errors       = 0;
    quiet_cycles = 0;
    bytes_taken  = 0;
    msgs_done    = 0;
    bare_ends    = 0;
    random_bytes = 0;
    kind_tally   = '{0, 0, 0};
    clear_message();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_script[i]) begin
      row = opening_script[i];
      send_byte(row.ch, row.typed, row.want);
    end

    // Random messages. Most are well formed (keywords, near misses, hex numbers of 1-8
    // digits, strings of printable and arbitrary bytes) so the classifier gets past its
    // first states; one in ten is raw noise. Token counts run past the limit on purpose.
    while (random_bytes < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 3) == 0);
      msg_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          b = 8'($urandom_range(1, 255));
          msg_q.push_back(b);
        end
      end else begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) msg_q.push_back(CHAR_SPACE);
        n_tok = $urandom_range(0, 5);
        for (int t = 0; t < n_tok; t++) begin
          if (t > 0) repeat ($urandom_range(0, 4) == 0 ? 2 : 1) msg_q.push_back(CHAR_SPACE);
          word = "";
          case ($urandom_range(0, 9))
            0, 1, 2: word = kw_word[$urandom_range(0, 2)];
            3: begin
              // near miss: short by one, one too long, or one letter swapped
              word = kw_word[$urandom_range(0, 2)];
              case ($urandom_range(0, 2))
                0:       word = word.substr(0, word.len() - 2);
                1:       word = {word, "s"};
                default: word[$urandom_range(0, word.len() - 1)] = 8'($urandom_range(33, 126));
              endcase
            end
            4, 5, 6: begin
              // mostly 1-5 digits, sometimes too many; the odd capital X or lowercase digit
              msg_q.push_back(CHAR_ZERO);
              msg_q.push_back(($urandom_range(0, 7) == 0) ? CHAR_UPPER_X : CHAR_LOWER_X);
              n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
              repeat (n) begin
                d = $urandom_range(0, 15);
                if ($urandom_range(0, 11) == 0) b = 8'(CHAR_LOWER_A + $urandom_range(0, 5));
                else if (d < 10) b = 8'(CHAR_ZERO + d);
                else b = 8'(CHAR_UPPER_A + d - 10);
                msg_q.push_back(b);
              end
            end
            7, 8: begin
              repeat ($urandom_range(1, 10)) begin
                b = 8'($urandom_range(33, 126));
                msg_q.push_back(b);
              end
            end
            default: begin
              repeat ($urandom_range(1, 10)) begin
                do b = 8'($urandom_range(1, 255)); while (b == CHAR_SPACE);
                msg_q.push_back(b);
              end
            end
          endcase
          for (int i = 0; i < word.len(); i++) msg_q.push_back(word[i]);
        end
        if ($urandom_range(0, 3) == 0) msg_q.push_back(CHAR_SPACE);
      end
      msg_q.push_back(CHAR_END);
      foreach (msg_q[i]) send_byte(msg_q[i], 1'b0, NO_CLAIM);
      random_bytes += msg_q.size();
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: the watchdog bounds this wait
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d bytes over %0d messages; %0d bare message ends checked.",
             bytes_taken, msgs_done, bare_ends);
    $display("Tokens checked: %0d keywords, %0d hex numbers, %0d strings; %0d mismatches.",
             kind_tally[KIND_KEYWORD], kind_tally[KIND_NUMBER], kind_tally[KIND_STRING],
             errors);
    if (errors == 0) begin
      $display("command_token_classifier_top verification clean");
    end else begin
      $display("command_token_classifier_top verification failed");
    end
    $finish;
  end

endmodule
